FILE: rtl/five_phase_stepper_sequencer_core_assert.svh
// Assertion macros for the checker file of the stepper sequencer.
`ifndef FIVE_PHASE_STEPPER_SEQUENCER_CORE_ASSERT_SVH
`define FIVE_PHASE_STEPPER_SEQUENCER_CORE_ASSERT_SVH

// Clocked check, switched off while reset is held
`define FSS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: check failed");

// Clocked check that also holds through reset
`define FSS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

FILE: rtl/fss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fss_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_DEFAULT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL          = 3'd5;

  // Register reset values
  localparam logic [11:0] RST_PWM_TOP        = 12'd4095;
  localparam logic [11:0] RST_DUTY_FLOOR     = 12'd5;
  localparam logic [11:0] RST_PERIOD_MIN     = 12'd15;
  localparam logic [11:0] RST_PERIOD_MAX     = 12'd4000;
  localparam logic [11:0] RST_PERIOD_DEFAULT = 12'd250;
  localparam logic [7:0]  RST_ACCEL          = 8'd5;

  // Drive direction codes
  localparam logic [1:0] MODE_FWD  = 2'd0;
  localparam logic [1:0] MODE_REV  = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  // Input item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  // Coil pattern table: enabled coils and forward coils per row
  localparam int unsigned ROWS = 20;
  localparam logic [4:0] EN_TAB [0:ROWS-1] = '{
    5'd13, 5'd5, 5'd21, 5'd20, 5'd22, 5'd18, 5'd26, 5'd10, 5'd11, 5'd9,
    5'd13, 5'd5, 5'd21, 5'd20, 5'd22, 5'd18, 5'd26, 5'd10, 5'd11, 5'd9};
  localparam logic [4:0] FW_TAB [0:ROWS-1] = '{
    5'd12, 5'd4, 5'd4, 5'd4, 5'd6, 5'd2, 5'd2, 5'd2, 5'd3, 5'd1,
    5'd1, 5'd1, 5'd17, 5'd16, 5'd16, 5'd16, 5'd24, 5'd8, 5'd8, 5'd8};

  // Configuration register file contents
  typedef struct packed {
    logic [11:0] pwm_top;
    logic [11:0] duty_floor;
    logic [11:0] period_min;
    logic [11:0] period_max;
    logic [11:0] period_default;
    logic [7:0]  accel;
  } cfg_t;

  // Operator settings as seen after an item
  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] duty;
    logic [11:0] period;
    logic        changed;
  } set_t;

endpackage

`default_nettype wire

FILE: rtl/five_phase_stepper_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Five-phase stepper sequencer core.
// Input register, then result register; the settings and step registers update as an item
// leaves the input register, when the result register is empty or its item is taken.
// Throughput: one item per cycle while out_stall is low.
// in_stall follows out_stall combinationally only when both registers hold an item.
// Synchronous active-low reset: registers to defaults, step 0, forward, duty pwm_top / 2.

module five_phase_stepper_sequencer_core #(
  parameter int TABLE_STEPS = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_kind,
  input  wire logic [4:0]                    in_buttons,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [4:0]                         out_step_index,
  output logic [4:0]                         out_coil_enable,
  output logic [7:0]                         out_port_a_bits,
  output logic [7:0]                         out_port_b_bits,
  output logic [11:0]                        out_duty_level,
  output logic [11:0]                        out_period_ms,
  output logic [1:0]                         out_direction_mode,
  output logic                               out_changed,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [11:0]                   cfg_data
);

  localparam logic [4:0] LAST_STEP = 5'(TABLE_STEPS - 1);
  localparam logic [5:0] STEP_WRAP = 6'(TABLE_STEPS);

  fss_pkg::cfg_t cfg;
  fss_pkg::set_t set_nxt;

  logic       s1_valid_r;
  logic       s1_kind_r;
  logic [4:0] s1_buttons_r;
  logic       advance, fire;
  logic [4:0] step_pos_r;
  logic [5:0] step_inc;
  logic [4:0] step_nxt;
  logic [4:0] pat_en;
  logic [7:0] pat_a, pat_b;

  logic        out_valid_r;
  logic [4:0]  step_index_r, coil_enable_r;
  logic [7:0]  port_a_r, port_b_r;
  logic [11:0] duty_r, period_r;
  logic [1:0]  mode_r;
  logic        changed_r;

  fss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fss_panel u_panel (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (fire),
    .kind    (s1_kind_r),
    .buttons (s1_buttons_r),
    .set_nxt (set_nxt)
  );

  fss_pattern u_pattern (
    .step        (step_pos_r),
    .coil_enable (pat_en),
    .port_a_bits (pat_a),
    .port_b_bits (pat_b)
  );

  // Pipeline flow: result register frees up when empty or taken
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind_r    <= in_kind;
      s1_buttons_r <= in_buttons;
    end
  end

  // Step advance on a tick, held while stopped
  assign step_inc = {1'b0, step_pos_r} + 6'd1;

  always_comb begin
    step_nxt = step_pos_r;
    if (s1_kind_r == fss_pkg::KIND_TICK) begin
      if (set_nxt.mode == fss_pkg::MODE_FWD) begin
        step_nxt = (step_inc >= STEP_WRAP) ? 5'd0 : step_inc[4:0];
      end else if (set_nxt.mode == fss_pkg::MODE_REV) begin
        step_nxt = (step_pos_r == 5'd0) ? LAST_STEP : step_pos_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_pos_r <= '0;
    end else if (fire) begin
      step_pos_r <= step_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      step_index_r  <= step_pos_r;
      coil_enable_r <= pat_en;
      port_a_r      <= pat_a;
      port_b_r      <= pat_b;
      duty_r        <= set_nxt.duty;
      period_r      <= set_nxt.period;
      mode_r        <= set_nxt.mode;
      changed_r     <= set_nxt.changed;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_step_index     = step_index_r;
  assign out_coil_enable    = coil_enable_r;
  assign out_port_a_bits    = port_a_r;
  assign out_port_b_bits    = port_b_r;
  assign out_duty_level     = duty_r;
  assign out_period_ms      = period_r;
  assign out_direction_mode = mode_r;
  assign out_changed        = changed_r;

endmodule

`default_nettype wire

FILE: rtl/fss_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module fss_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [11:0]                   cfg_data,
  output fss_pkg::cfg_t                      cfg
);

  fss_pkg::cfg_t cfg_r;

  // Writes are taken in any cycle
  assign cfg_ready = 1'b1;

  // Register file, indexes outside the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_top        <= fss_pkg::RST_PWM_TOP;
      cfg_r.duty_floor     <= fss_pkg::RST_DUTY_FLOOR;
      cfg_r.period_min     <= fss_pkg::RST_PERIOD_MIN;
      cfg_r.period_max     <= fss_pkg::RST_PERIOD_MAX;
      cfg_r.period_default <= fss_pkg::RST_PERIOD_DEFAULT;
      cfg_r.accel          <= fss_pkg::RST_ACCEL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fss_pkg::REG_PWM_TOP:        cfg_r.pwm_top        <= cfg_data;
        fss_pkg::REG_DUTY_FLOOR:     cfg_r.duty_floor     <= cfg_data;
        fss_pkg::REG_PERIOD_MIN:     cfg_r.period_min     <= cfg_data;
        fss_pkg::REG_PERIOD_MAX:     cfg_r.period_max     <= cfg_data;
        fss_pkg::REG_PERIOD_DEFAULT: cfg_r.period_default <= cfg_data;
        fss_pkg::REG_ACCEL:          cfg_r.accel          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/fss_pattern.sv
`timescale 1ns / 1ps
`default_nettype none

module fss_pattern (
  input  wire logic [4:0] step,
  output logic [4:0]      coil_enable,
  output logic [7:0]      port_a_bits,
  output logic [7:0]      port_b_bits
);

  logic [4:0] row;
  logic [4:0] fw;

  // Steps past the table wrap back by one table length
  assign row = (step >= 5'(fss_pkg::ROWS)) ? step - 5'(fss_pkg::ROWS) : step;

  assign coil_enable = fss_pkg::EN_TAB[row];
  assign fw          = fss_pkg::FW_TAB[row];

  // Coils one to three on port A bits 5..7, coils four and five on port B bits 0..1
  assign port_a_bits = {fw[2:0], 5'b0};
  assign port_b_bits = {6'b0, fw[4:3]};

endmodule

`default_nettype wire

FILE: rtl/fss_panel.sv
`timescale 1ns / 1ps
`default_nettype none

module fss_panel (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fss_pkg::cfg_t cfg,
  input  wire logic          fire,
  input  wire logic          kind,
  input  wire logic [4:0]    buttons,
  output fss_pkg::set_t      set_nxt
);

  logic [1:0]  mode_r;
  logic [11:0] duty_r;
  logic [11:0] period_r;
  logic [11:0] adj_r;
  logic        changed_r;
  logic [11:0] adj_nxt;

  logic        b_p_up, b_p_dn, b_rst, b_d_up, b_d_dn;
  logic [12:0] p_sum, p_dif, d_sum, d_dif, grow;
  logic [11:0] p_up_val, p_dn_val, d_up_val, d_dn_val, grow_val;
  logic [1:0]  mode_step;

  // Active-low buttons
  assign b_p_up = !buttons[0];
  assign b_d_dn = !buttons[1];
  assign b_p_dn = !buttons[2];
  assign b_rst  = !buttons[3];
  assign b_d_up = !buttons[4];

  // Adjusted values with their clamps
  assign p_sum = {1'b0, period_r} + {1'b0, adj_r};
  assign p_dif = {1'b0, period_r} - {1'b0, adj_r};
  assign d_sum = {1'b0, duty_r} + {1'b0, adj_r};
  assign d_dif = {1'b0, duty_r} - {1'b0, adj_r};

  assign p_up_val = (p_sum > {1'b0, cfg.period_max}) ? cfg.period_max : p_sum[11:0];
  assign p_dn_val = (p_dif[12] || p_dif[11:0] < cfg.period_min) ? cfg.period_min
                                                                 : p_dif[11:0];
  assign d_up_val = (d_sum >= {1'b0, cfg.pwm_top}) ? cfg.pwm_top : d_sum[11:0];
  assign d_dn_val = (d_dif[12] || d_dif[11:0] < cfg.duty_floor) ? cfg.duty_floor
                                                                 : d_dif[11:0];

  // Accelerating increment, saturated at full scale
  assign grow     = {1'b0, adj_r} + {5'b0, cfg.accel};
  assign grow_val = grow[12] ? 12'hFFF : grow[11:0];

  // Mode sequence on the reset button: forward, reverse, stop
  always_comb begin
    unique case (mode_r)
      fss_pkg::MODE_FWD: mode_step = fss_pkg::MODE_REV;
      fss_pkg::MODE_REV: mode_step = fss_pkg::MODE_STOP;
      default:           mode_step = fss_pkg::MODE_FWD;
    endcase
  end

  // Button priority: period up, period down, reset, duty up, duty down
  always_comb begin
    set_nxt.mode    = mode_r;
    set_nxt.duty    = duty_r;
    set_nxt.period  = period_r;
    set_nxt.changed = changed_r;
    adj_nxt         = adj_r;
    if (kind == fss_pkg::KIND_POLL) begin
      set_nxt.changed = 1'b1;
      if (b_p_up) begin
        set_nxt.period = p_up_val;
        adj_nxt        = grow_val;
      end else if (b_p_dn) begin
        set_nxt.period = p_dn_val;
        adj_nxt        = grow_val;
      end else if (b_rst) begin
        set_nxt.period = cfg.period_default;
        set_nxt.duty   = cfg.pwm_top >> 1;
        set_nxt.mode   = mode_step;
        adj_nxt        = {3'b0, cfg.accel, 1'b0};
      end else if (b_d_up) begin
        set_nxt.duty = d_up_val;
        adj_nxt      = grow_val;
      end else if (b_d_dn) begin
        set_nxt.duty = d_dn_val;
        adj_nxt      = grow_val;
      end else begin
        set_nxt.changed = 1'b0;
        adj_nxt         = {4'b0, cfg.accel};
      end
    end
  end

  // Settings state, updated once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= fss_pkg::MODE_FWD;
      duty_r    <= fss_pkg::RST_PWM_TOP >> 1;
      period_r  <= fss_pkg::RST_PERIOD_DEFAULT;
      adj_r     <= '0;
      changed_r <= 1'b0;
    end else if (fire) begin
      mode_r    <= set_nxt.mode;
      duty_r    <= set_nxt.duty;
      period_r  <= set_nxt.period;
      adj_r     <= adj_nxt;
      changed_r <= set_nxt.changed;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fss_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "five_phase_stepper_sequencer_core_assert.svh"

module fss_checker #(
  parameter int TABLE_STEPS = 20
) (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_valid,
  input wire logic         out_stall,
  input wire logic [4:0]   out_step_index,
  input wire logic [4:0]   out_coil_enable,
  input wire logic [7:0]   out_port_a_bits,
  input wire logic [7:0]   out_port_b_bits,
  input wire logic [11:0]  out_duty_level,
  input wire logic [11:0]  out_period_ms,
  input wire logic [1:0]   out_direction_mode
);

  // No result straight out of reset
  `FSS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  // A stalled item holds its settings
  `FSS_ASSERT(a_out_hold, clk, rst_n,
    out_valid && out_stall |=> out_valid && $stable(out_step_index) &&
    $stable(out_duty_level) && $stable(out_period_ms) && $stable(out_direction_mode))

  // Step within the table, mode never the unused code
  `FSS_ASSERT(a_step_mode, clk, rst_n,
    out_valid |-> (6'(out_step_index) < 6'(TABLE_STEPS)) &&
    (out_direction_mode != 2'd3))

  // Forward bits only on enabled coils, unused port bits clear
  `FSS_ASSERT(a_fw_in_en, clk, rst_n,
    out_valid |-> ((out_port_a_bits[7:5] & ~out_coil_enable[2:0]) == 3'b0) &&
    ((out_port_b_bits[1:0] & ~out_coil_enable[4:3]) == 2'b0) &&
    (out_port_a_bits[4:0] == 5'b0) && (out_port_b_bits[7:2] == 6'b0))

endmodule

bind five_phase_stepper_sequencer_core fss_checker #(.TABLE_STEPS(TABLE_STEPS)) u_fss_checker (.*);

`default_nettype wire

FILE: test/tb_five_phase_stepper_sequencer_core.sv
`timescale 1ns / 1ps

// One result as it leaves the sequencer
typedef struct packed {
  logic [4:0]  step_index;
  logic [4:0]  coil_enable;
  logic [7:0]  port_a_bits;
  logic [7:0]  port_b_bits;
  logic [11:0] duty_level;
  logic [11:0] period_ms;
  logic [1:0]  direction_mode;
  logic        changed;
} step_report_t;

// Active-low button positions, in bit order of in_buttons
localparam int BTN_PERIOD_UP   = 0;
localparam int BTN_DUTY_DOWN   = 1;
localparam int BTN_PERIOD_DOWN = 2;
localparam int BTN_RESET       = 3;
localparam int BTN_DUTY_UP     = 4;
localparam logic [4:0] BTN_NONE = 5'h1F;
localparam int SEQ_STEPS = 20;

// Tracks the sequencer's settings and step, and checks its reports in order
class stepper_scoreboard;
  logic [11:0] pwm_top, duty_floor, period_min, period_max, period_default;
  logic [7:0]  accel;
  logic [4:0]  step_pos;
  logic [1:0]  mode;
  logic [11:0] duty_now, period_now, adjust_step;
  logic        changed_flag;
  logic [4:0]  en_rows [SEQ_STEPS];
  logic [4:0]  fw_rows [SEQ_STEPS];
  step_report_t pending_reports[$];
  int errors;
  int results_seen;

  function new();
    en_rows = '{5'd13, 5'd5, 5'd21, 5'd20, 5'd22, 5'd18, 5'd26, 5'd10, 5'd11, 5'd9,
                5'd13, 5'd5, 5'd21, 5'd20, 5'd22, 5'd18, 5'd26, 5'd10, 5'd11, 5'd9};
    fw_rows = '{5'd12, 5'd4, 5'd4, 5'd4, 5'd6, 5'd2, 5'd2, 5'd2, 5'd3, 5'd1,
                5'd1, 5'd1, 5'd17, 5'd16, 5'd16, 5'd16, 5'd24, 5'd8, 5'd8, 5'd8};
    pwm_top        = fss_pkg::RST_PWM_TOP;
    duty_floor     = fss_pkg::RST_DUTY_FLOOR;
    period_min     = fss_pkg::RST_PERIOD_MIN;
    period_max     = fss_pkg::RST_PERIOD_MAX;
    period_default = fss_pkg::RST_PERIOD_DEFAULT;
    accel          = fss_pkg::RST_ACCEL;
    step_pos       = '0;
    mode           = fss_pkg::MODE_FWD;
    duty_now       = pwm_top >> 1;
    period_now     = period_default;
    adjust_step    = '0;
    changed_flag   = 1'b0;
    errors         = 0;
    results_seen   = 0;
  endfunction

  function void write_reg(logic [fss_pkg::CFG_IDX_W-1:0] idx, logic [11:0] data);
    case (idx)
      fss_pkg::REG_PWM_TOP:        pwm_top = data;
      fss_pkg::REG_DUTY_FLOOR:     duty_floor = data;
      fss_pkg::REG_PERIOD_MIN:     period_min = data;
      fss_pkg::REG_PERIOD_MAX:     period_max = data;
      fss_pkg::REG_PERIOD_DEFAULT: period_default = data;
      fss_pkg::REG_ACCEL:          accel = data[7:0];
      default: ;
    endcase
  endfunction

  // adjustment grows while a button is held, saturating at 12 bits
  function void grow_adjust();
    int a;
    a = int'(adjust_step) + int'(accel);
    adjust_step = (a > 4095) ? 12'd4095 : a[11:0];
  endfunction

  function int pending();
    return pending_reports.size();
  endfunction

  function void note_item(logic kind, logic [4:0] btn);
    step_report_t r;
    int v;
    logic [4:0] row;
    logic [4:0] fw;
    // button poll, fixed priority
    if (kind == fss_pkg::KIND_POLL) begin
      if (!btn[BTN_PERIOD_UP]) begin
        v = int'(period_now) + int'(adjust_step);
        if (v > int'(period_max)) v = int'(period_max);
        period_now = v[11:0];
        grow_adjust();
        changed_flag = 1'b1;
      end else if (!btn[BTN_PERIOD_DOWN]) begin
        v = int'(period_now) - int'(adjust_step);
        if (v < int'(period_min)) v = int'(period_min);
        period_now = v[11:0];
        grow_adjust();
        changed_flag = 1'b1;
      end else if (!btn[BTN_RESET]) begin
        period_now = period_default;
        duty_now = pwm_top >> 1;
        case (mode)
          fss_pkg::MODE_FWD: mode = fss_pkg::MODE_REV;
          fss_pkg::MODE_REV: mode = fss_pkg::MODE_STOP;
          default:           mode = fss_pkg::MODE_FWD;
        endcase
        adjust_step = {3'b0, accel, 1'b0};
        changed_flag = 1'b1;
      end else if (!btn[BTN_DUTY_UP]) begin
        v = int'(duty_now) + int'(adjust_step);
        if (v >= int'(pwm_top)) v = int'(pwm_top);
        duty_now = v[11:0];
        grow_adjust();
        changed_flag = 1'b1;
      end else if (!btn[BTN_DUTY_DOWN]) begin
        v = int'(duty_now) - int'(adjust_step);
        if (v < int'(duty_floor)) v = int'(duty_floor);
        duty_now = v[11:0];
        grow_adjust();
        changed_flag = 1'b1;
      end else begin
        adjust_step = {4'b0, accel};
        changed_flag = 1'b0;
      end
    end
    // report shows the step before any advance
    row = (step_pos >= 5'(SEQ_STEPS)) ? step_pos - 5'(SEQ_STEPS) : step_pos;
    fw = fw_rows[row];
    r.step_index     = step_pos;
    r.coil_enable    = en_rows[row];
    r.port_a_bits    = {fw[2:0], 5'b0};
    r.port_b_bits    = {6'b0, fw[4:3]};
    r.duty_level     = duty_now;
    r.period_ms      = period_now;
    r.direction_mode = mode;
    r.changed        = changed_flag;
    pending_reports.push_back(r);
    // tick advances with wrap; stopped holds
    if (kind == fss_pkg::KIND_TICK) begin
      if (mode == fss_pkg::MODE_FWD)
        step_pos = (6'(step_pos) + 6'd1 >= 6'(SEQ_STEPS)) ? 5'd0 : step_pos + 5'd1;
      else if (mode == fss_pkg::MODE_REV)
        step_pos = (step_pos == 5'd0) ? 5'(SEQ_STEPS - 1) : step_pos - 5'd1;
    end
  endfunction

  function void check_result(step_report_t got);
    step_report_t want;
    results_seen++;
    if (pending_reports.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result %0d arrived with none outstanding", $realtime, results_seen);
      return;
    end
    want = pending_reports.pop_front();
    if (got.step_index !== want.step_index || got.coil_enable !== want.coil_enable ||
        got.port_a_bits !== want.port_a_bits || got.port_b_bits !== want.port_b_bits ||
        got.duty_level !== want.duty_level || got.period_ms !== want.period_ms ||
        got.direction_mode !== want.direction_mode || got.changed !== want.changed) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: result %0d wrong", $realtime, results_seen);
        $display("  expected step %0d coils %h portA %h portB %h",
                 want.step_index, want.coil_enable, want.port_a_bits, want.port_b_bits);
        $display("           duty %0d period %0d mode %0d chg %0d",
                 want.duty_level, want.period_ms, want.direction_mode, want.changed);
        $display("  actual   step %0d coils %h portA %h portB %h",
                 got.step_index, got.coil_enable, got.port_a_bits, got.port_b_bits);
        $display("           duty %0d period %0d mode %0d chg %0d",
                 got.duty_level, got.period_ms, got.direction_mode, got.changed);
      end
    end
  endfunction
endclass

module tb_five_phase_stepper_sequencer_core;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 60;
  localparam logic [fss_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_kind;
  logic [4:0] in_buttons;
  logic out_valid;
  logic out_stall;
  logic [4:0] out_step_index;
  logic [4:0] out_coil_enable;
  logic [7:0] out_port_a_bits;
  logic [7:0] out_port_b_bits;
  logic [11:0] out_duty_level;
  logic [11:0] out_period_ms;
  logic [1:0] out_direction_mode;
  logic out_changed;
  logic cfg_valid;
  logic cfg_ready;
  logic [fss_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [11:0] cfg_data;

  stepper_scoreboard sb;
  bit no_idle;
  bit hold_req;
  bit stall_window;
  int phase_items;
  int stuck_cycles;
  bit progress;

  five_phase_stepper_sequencer_core dut (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watch every handshake at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      progress = 1'b0;
      if (out_valid && !out_stall) begin
        sb.check_result('{out_step_index, out_coil_enable, out_port_a_bits, out_port_b_bits,
                          out_duty_level, out_period_ms, out_direction_mode, out_changed});
        progress = 1'b1;
      end
      if (in_valid && !in_stall) begin
        sb.note_item(in_kind, in_buttons);
        progress = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        progress = 1'b1;
      end
      stuck_cycles = progress ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    stall_window = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!no_idle && stall_window && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        if ($urandom_range(0, 63) == 0) stall_window = !stall_window;
      end
    end
  end

  function automatic logic [4:0] press(int pos);
    return BTN_NONE & ~(5'b1 << pos);
  endfunction

  // Offer one item and hold it until taken
  task automatic push_item(logic kind, logic [4:0] btn, bit gappy);
    in_kind = kind;
    in_buttons = btn;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    phase_items++;
    if (gappy && !no_idle && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      in_kind = 1'($urandom);
      in_buttons = 5'($urandom);
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Wait until every outstanding report is back, then past the pipeline
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_settings(logic [11:0] top, logic [11:0] floor_lvl, logic [11:0] pmin,
                                logic [11:0] pmax, logic [11:0] pdef, logic [11:0] acc);
    logic [11:0] vals [6];
    vals = '{top, floor_lvl, pmin, pmax, pdef, acc};
    drain();
    cfg_valid = 1'b1;
    for (int i = 0; i < 6; i++) begin
      cfg_index = fss_pkg::CFG_IDX_W'(i);
      cfg_data = vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  // Mostly held-button runs with ticks between, some tick runs and noise
  task automatic run_random(int n, int phase);
    int sel;
    int len;
    bit gappy;
    bit done_pressure;
    logic [4:0] pat;
    done_pressure = 1'b0;
    phase_items = 0;
    while (phase_items < n) begin
      sel = $urandom_range(0, 99);
      gappy = 1'($urandom_range(0, 1));
      if (phase == 1 && !done_pressure && phase_items >= 60) begin
        hold_req = 1'b1;
        done_pressure = 1'b1;
      end
      if (phase == 2 && !done_pressure && phase_items >= 60) begin
        drain();
        done_pressure = 1'b1;
      end
      if (sel < 70) begin
        pat = 5'($urandom) & press($urandom_range(0, 4));
        len = $urandom_range(1, 25);
        for (int i = 0; i < len && phase_items < n; i++) begin
          if ($urandom_range(0, 3) == 0) push_item(fss_pkg::KIND_TICK, 5'($urandom), gappy);
          push_item(fss_pkg::KIND_POLL, pat, gappy);
        end
        push_item(fss_pkg::KIND_POLL, BTN_NONE, gappy);
      end else if (sel < 85) begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len && phase_items < n; i++)
          push_item(fss_pkg::KIND_TICK, 5'($urandom), gappy);
      end else begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len && phase_items < n; i++)
          push_item(1'($urandom), 5'($urandom), gappy);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = fss_pkg::KIND_TICK;
    in_buttons = BTN_NONE;
    cfg_valid = 1'b0;
    cfg_index = fss_pkg::REG_PWM_TOP;
    cfg_data = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    stuck_cycles = 0;
    phase_items = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every button alone, priorities, mode cycle and both wraps
    push_item(fss_pkg::KIND_TICK, BTN_NONE, 1'b0);
    push_item(fss_pkg::KIND_TICK, BTN_NONE, 1'b0);
    push_item(fss_pkg::KIND_POLL, press(BTN_PERIOD_UP), 1'b0);
    push_item(fss_pkg::KIND_POLL, BTN_NONE, 1'b0);
    push_item(fss_pkg::KIND_POLL, 5'b00000, 1'b0);
    push_item(fss_pkg::KIND_POLL, press(BTN_PERIOD_DOWN), 1'b0);
    push_item(fss_pkg::KIND_POLL, press(BTN_DUTY_UP), 1'b0);
    push_item(fss_pkg::KIND_POLL, press(BTN_DUTY_DOWN), 1'b0);
    push_item(fss_pkg::KIND_POLL, press(BTN_RESET) & press(BTN_DUTY_UP), 1'b0);
    push_item(fss_pkg::KIND_TICK, BTN_NONE, 1'b0);
    push_item(fss_pkg::KIND_TICK, BTN_NONE, 1'b0);
    push_item(fss_pkg::KIND_TICK, BTN_NONE, 1'b0);
    push_item(fss_pkg::KIND_POLL, press(BTN_RESET), 1'b0);
    push_item(fss_pkg::KIND_TICK, BTN_NONE, 1'b0);
    push_item(fss_pkg::KIND_POLL, press(BTN_RESET), 1'b0);
    push_item(fss_pkg::KIND_TICK, 5'b00000, 1'b0);
    push_item(fss_pkg::KIND_POLL, press(BTN_PERIOD_DOWN) & press(BTN_DUTY_DOWN), 1'b0);
    push_item(fss_pkg::KIND_POLL, press(BTN_DUTY_UP) & press(BTN_DUTY_DOWN), 1'b0);
    push_item(fss_pkg::KIND_POLL, BTN_NONE, 1'b0);
    run_random(130, 0);

    // Widest clamps, fastest growth; accel data carries set upper bits
    write_settings(12'd4095, 12'd0, 12'd1, 12'd4095, 12'd4095, 12'hFFF);
    run_random(150, 1);

    // Narrowest values with inverted clamps and no growth; spare index ignored
    write_settings(12'd1, 12'd4095, 12'd4095, 12'd1, 12'd1, 12'd0);
    drain();
    cfg_valid = 1'b1;
    cfg_index = CFG_IDX_SPARE;
    cfg_data = 12'($urandom);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    run_random(150, 2);

    for (int p = 3; p < 5; p++) begin
      write_settings(12'($urandom_range(1, 4095)), 12'($urandom_range(0, 4095)),
                     12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                     12'($urandom_range(1, 4095)), 12'($urandom_range(0, 4095)));
      run_random(150, p);
    end

    // Closing stretch at reset settings, both sides flat out
    write_settings(fss_pkg::RST_PWM_TOP, fss_pkg::RST_DUTY_FLOOR, fss_pkg::RST_PERIOD_MIN,
                   fss_pkg::RST_PERIOD_MAX, fss_pkg::RST_PERIOD_DEFAULT,
                   {4'b0, fss_pkg::RST_ACCEL});
    no_idle = 1'b1;
    run_random(150, 5);

    drain();
    repeat (10) @(negedge clk);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/fss_pkg.sv
rtl/fss_cfg_regs.sv
rtl/fss_pattern.sv
rtl/fss_panel.sv
rtl/five_phase_stepper_sequencer_core.sv
rtl/fss_checker.sv
test/tb_five_phase_stepper_sequencer_core.sv
